// ===== src/lpt_rank_subset_selector_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rank subset selector
// Concurrent checks clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef LPT_RANK_SUBSET_SELECTOR_TOP_DEFINES_SVH
`define LPT_RANK_SUBSET_SELECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LRSS_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clock) \
   disable iff (reset) (ante) |-> (cons)) else $error("lrss check failed");
`define LRSS_ASSERT_NXT(lbl, ante, cons) lbl: assert property (@(posedge clock) \
   disable iff (reset) (ante) |=> (cons)) else $error("lrss check failed");
`else
`define LRSS_ASSERT_IMP(lbl, ante, cons)
`define LRSS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/lrss_pkg.sv =====
// ----------------------------------------------------------------------------
// lrss_pkg
// Shared types and constants of the rank subset selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lrss_pkg;
   localparam int COST_W       = 32;
   localparam int TOT_W        = 48;
   localparam int IDX_W        = 6;
   localparam int MAXSEL_W     = 7;
   localparam int THRESH_W     = 16;
   localparam int CMD_W        = 2;
   localparam int DEF_MAX_RANKS = 64;
   localparam int QUEUE_DEPTH  = 4;
   localparam int RSP_DEPTH    = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START = 2'd2;

   localparam logic REG_MAX_SELECTED = 1'b0;
   localparam logic REG_THRESHOLD    = 1'b1;
   localparam logic [MAXSEL_W-1:0] MAXSEL_RESET = 7'd4;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd3277;
   localparam logic [TOT_W-1:0]    TOTAL_MAX    = {TOT_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_ADD,
      KIND_START
   } lrss_kind_type;

   typedef struct packed {
      lrss_kind_type     kind;
      logic [COST_W-1:0] cost;
   } lrss_item_type;

   typedef struct packed {
      logic [IDX_W-1:0] rank_index;
      logic             from_back;
      logic             none_selected;
      logic             last;
   } lrss_rsp_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [IDX_W-1:0]  idx;
   } lrss_entry_type;

   typedef struct packed {
      logic              load;
      logic              shift;
      logic [COST_W-1:0] cost;
      logic [IDX_W-1:0]  idx;
   } lrss_chain_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_EMPTY,
      ST_THR,
      ST_INIT,
      ST_CHECK,
      ST_READ,
      ST_MUL,
      ST_DECIDE,
      ST_EMIT_RD,
      ST_EMIT_WR
   } lrss_state_type;
endpackage
`default_nettype wire

// ===== src/lrss_fifo.sv =====
// ----------------------------------------------------------------------------
// lrss_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lpt_rank_subset_selector_top_defines.svh"
module lrss_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wptr_ff] <= wdata;
      end
   end

   `LRSS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= CW'(DEPTH))
   `LRSS_ASSERT_NXT(a_cnt_up, do_push && !do_pop, cnt_ff == $past(cnt_ff) + 1'b1)
   `LRSS_ASSERT_NXT(a_cnt_down, do_pop && !do_push, cnt_ff == $past(cnt_ff) - 1'b1)
endmodule
`default_nettype wire

// ===== src/lrss_front.sv =====
// ----------------------------------------------------------------------------
// lrss_front
// Decodes request commands, drops unknown codes, queues items for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrss_front
   import lrss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [CMD_W-1:0]  cmd,
   input  wire logic [COST_W-1:0] cost_value,
   input  wire logic              q_pop,
   output lrss_item_type          q_item,
   output logic                   q_empty
);
   lrss_item_type item;
   logic          known;
   logic [$bits(lrss_item_type)-1:0] q_raw;

   always_comb begin
      item.cost = cost_value;
      known     = 1'b1;
      case (cmd)
         CMD_LOAD:  item.kind = KIND_LOAD;
         CMD_ADD:   item.kind = KIND_ADD;
         CMD_START: item.kind = KIND_START;
         default: begin
            item.kind = KIND_LOAD;
            known     = 1'b0;
         end
      endcase
   end

   lrss_fifo #(
      .WIDTH($bits(lrss_item_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push && known),
      .wdata (item),
      .full  (full),
      .pop   (q_pop),
      .rdata (q_raw),
      .empty (q_empty)
   );

   assign q_item = lrss_item_type'(q_raw);
endmodule
`default_nettype wire

// ===== src/lrss_chain.sv =====
// ----------------------------------------------------------------------------
// lrss_chain
// Insertion sort chain: keeps loaded ranks ordered by cost, descending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrss_chain
   import lrss_pkg::*;
#(
   parameter int MAX_RANKS = DEF_MAX_RANKS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  lrss_chain_ctl_type ctl,
   output lrss_entry_type    head
);
   logic [MAX_RANKS-1:0] valid_ff;
   lrss_entry_type       cell_ff [MAX_RANKS];
   logic [MAX_RANKS-1:0] keep;
   lrss_entry_type       fresh;

   assign fresh.cost = ctl.cost;
   assign fresh.idx  = ctl.idx;
   assign head       = cell_ff[0];

   // equal costs stay ahead: the newcomer has the higher load index
   always_comb begin
      for (int i = 0; i < MAX_RANKS; i++) begin
         keep[i] = valid_ff[i] && (cell_ff[i].cost >= ctl.cost);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.load) begin
         valid_ff <= {valid_ff[MAX_RANKS-2:0], 1'b1};
      end else if (ctl.shift) begin
         valid_ff <= {1'b0, valid_ff[MAX_RANKS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         if (!keep[0]) begin
            cell_ff[0] <= fresh;
         end
         for (int i = 1; i < MAX_RANKS; i++) begin
            if (!keep[i]) begin
               cell_ff[i] <= keep[i-1] ? fresh : cell_ff[i-1];
            end
         end
      end else if (ctl.shift) begin
         for (int i = 0; i < MAX_RANKS - 1; i++) begin
            cell_ff[i] <= cell_ff[i+1];
         end
      end
   end
endmodule
`default_nettype wire

// ===== src/lrss_engine.sv =====
// ----------------------------------------------------------------------------
// lrss_engine
// Executes queued items: loads, totals, and the subset selection run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lpt_rank_subset_selector_top_defines.svh"
module lrss_engine
   import lrss_pkg::*;
#(
   parameter int MAX_RANKS = DEF_MAX_RANKS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [MAXSEL_W-1:0] max_selected,
   input  wire logic [THRESH_W-1:0] balance_threshold,
   input  lrss_item_type            q_item,
   input  wire logic                q_empty,
   output logic                     q_pop,
   output lrss_chain_ctl_type       chain_ctl,
   input  lrss_entry_type           chain_head,
   output logic                     out_push,
   output lrss_rsp_type             out_data,
   input  wire logic                out_full
);
   localparam int AW    = $clog2(MAX_RANKS);
   localparam int CW    = $clog2(MAX_RANKS + 1);
   localparam int SUM_W = COST_W + CW;
   localparam int LHS_W = SUM_W + CW;
   localparam int RHS_W = TOT_W + CW;
   localparam int CN_W  = COST_W + CW;
   localparam int THR_W = TOT_W + THRESH_W;

   lrss_state_type state_ff, state_in;

   lrss_entry_type sort_mem [MAX_RANKS];
   lrss_entry_type rda_ff, rdb_ff;
   logic [AW-1:0]  addr_a, addr_b;
   logic           mem_we;

   logic [CW-1:0]    count_ff, n_ff, limit_ff, front_ff, back_ff, ptr_ff;
   logic [TOT_W-1:0] total_ff, tot_run_ff;
   logic [THR_W-1:0] thr_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [COST_W-1:0] cf_ff, cb_ff;
   logic [LHS_W-1:0] lhs_ff;
   logic [RHS_W-1:0] rhs_ff;
   logic [CN_W-1:0]  cfn_ff, cbn_ff;
   logic             emit_back_ff;

   logic [TOT_W:0]   total_sum;
   logic [CW-1:0]    limit_in;
   logic [THR_W-1:0] diff_f, diff_b;
   logic             bal_f, bal_b, balanced, grow_back, grow_front;
   logic             last_res, can_load;

   assign total_sum = {1'b0, tot_run_ff} + (TOT_W + 1)'(q_item.cost);
   assign limit_in  = (max_selected > MAXSEL_W'(count_ff)) ? count_ff
                                                          : CW'(max_selected);
   assign can_load  = (count_ff < CW'(MAX_RANKS));

   assign diff_f   = THR_W'(cfn_ff) - THR_W'(total_ff);
   assign diff_b   = THR_W'(total_ff) - THR_W'(cbn_ff);
   assign bal_f    = (THR_W'(cfn_ff) < THR_W'(total_ff)) || ((diff_f << 16) < thr_ff);
   assign bal_b    = (THR_W'(total_ff) < THR_W'(cbn_ff)) || ((diff_b << 16) < thr_ff);
   assign balanced = bal_f && bal_b;
   assign grow_back  = RHS_W'(lhs_ff) > rhs_ff;
   assign grow_front = RHS_W'(lhs_ff) < rhs_ff;

   assign last_res = emit_back_ff ? (ptr_ff == n_ff - 1'b1)
                                  : ((ptr_ff == front_ff - 1'b1) && (back_ff == '0));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && q_item.kind == KIND_START) state_in = ST_COPY;
         end
         ST_COPY: begin
            if (ptr_ff == n_ff) state_in = (limit_ff == '0) ? ST_EMPTY : ST_THR;
         end
         ST_EMPTY: begin
            if (!out_full) state_in = ST_IDLE;
         end
         ST_THR:   state_in = ST_INIT;
         ST_INIT:  state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = (front_ff + back_ff < limit_ff) ? ST_READ : ST_EMIT_RD;
         end
         ST_READ:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_DECIDE;
         ST_DECIDE: begin
            state_in = (!grow_back && !grow_front) || balanced ? ST_EMIT_RD : ST_CHECK;
         end
         ST_EMIT_RD: state_in = ST_EMIT_WR;
         ST_EMIT_WR: begin
            if (!out_full) state_in = last_res ? ST_IDLE : ST_EMIT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop           = 1'b0;
      chain_ctl.load  = 1'b0;
      chain_ctl.shift = 1'b0;
      chain_ctl.cost  = q_item.cost;
      chain_ctl.idx   = IDX_W'(count_ff);
      mem_we          = 1'b0;
      addr_a          = ptr_ff[AW-1:0];
      addr_b          = ptr_ff[AW-1:0];
      out_push        = 1'b0;
      out_data.rank_index    = rda_ff.idx;
      out_data.from_back     = emit_back_ff;
      out_data.none_selected = 1'b0;
      out_data.last          = last_res;
      case (state_ff)
         ST_IDLE: begin
            q_pop          = !q_empty;
            chain_ctl.load = !q_empty && q_item.kind == KIND_LOAD && can_load;
         end
         ST_COPY: begin
            mem_we          = (ptr_ff != n_ff);
            chain_ctl.shift = (ptr_ff != n_ff);
         end
         ST_EMPTY: begin
            out_push               = !out_full;
            out_data.rank_index    = '0;
            out_data.from_back     = 1'b0;
            out_data.none_selected = 1'b1;
            out_data.last          = 1'b1;
         end
         ST_THR: addr_a = '0;
         ST_READ: begin
            addr_a = front_ff[AW-1:0];
            addr_b = AW'(n_ff - 1'b1 - back_ff);
         end
         ST_EMIT_WR: out_push = !out_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sort_mem[ptr_ff[AW-1:0]] <= chain_head;
      end
      rda_ff <= sort_mem[addr_a];
      rdb_ff <= sort_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         tot_run_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && !q_empty) begin
            case (q_item.kind)
               KIND_LOAD: begin
                  if (can_load) count_ff <= count_ff + 1'b1;
               end
               KIND_ADD: begin
                  tot_run_ff <= total_sum[TOT_W] ? TOTAL_MAX : total_sum[TOT_W-1:0];
               end
               KIND_START: begin
                  count_ff   <= '0;
                  tot_run_ff <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            n_ff     <= count_ff;
            limit_ff <= limit_in;
            total_ff <= tot_run_ff;
            ptr_ff   <= '0;
         end
         ST_COPY: begin
            if (ptr_ff != n_ff) ptr_ff <= ptr_ff + 1'b1;
         end
         ST_THR: thr_ff <= THR_W'(total_ff) * THR_W'(balance_threshold);
         ST_INIT: begin
            sum_ff   <= SUM_W'(rda_ff.cost);
            front_ff <= CW'(1);
            back_ff  <= '0;
         end
         ST_CHECK: begin
            ptr_ff       <= '0;
            emit_back_ff <= 1'b0;
         end
         ST_MUL: begin
            cf_ff  <= rda_ff.cost;
            cb_ff  <= rdb_ff.cost;
            lhs_ff <= LHS_W'(sum_ff) * LHS_W'(n_ff);
            rhs_ff <= RHS_W'(total_ff) * RHS_W'(front_ff + back_ff);
            cfn_ff <= CN_W'(rda_ff.cost) * CN_W'(n_ff);
            cbn_ff <= CN_W'(rdb_ff.cost) * CN_W'(n_ff);
         end
         ST_DECIDE: begin
            ptr_ff       <= '0;
            emit_back_ff <= 1'b0;
            if (grow_back) begin
               sum_ff  <= sum_ff + SUM_W'(cb_ff);
               back_ff <= back_ff + 1'b1;
            end else if (grow_front) begin
               sum_ff   <= sum_ff + SUM_W'(cf_ff);
               front_ff <= front_ff + 1'b1;
            end
         end
         ST_EMIT_WR: begin
            if (!out_full && !last_res) begin
               if (!emit_back_ff && ptr_ff == front_ff - 1'b1) begin
                  ptr_ff       <= n_ff - back_ff;
                  emit_back_ff <= 1'b1;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   `LRSS_ASSERT_IMP(a_sel_in_limit, state_ff == ST_CHECK, front_ff + back_ff <= limit_ff)
   `LRSS_ASSERT_IMP(a_front_nonzero, state_ff == ST_EMIT_WR, front_ff != '0)
   `LRSS_ASSERT_IMP(a_emit_in_range, state_ff == ST_EMIT_WR, ptr_ff < n_ff)
endmodule
`default_nettype wire

// ===== src/lpt_rank_subset_selector_top.sv =====
// ----------------------------------------------------------------------------
// lpt_rank_subset_selector_top
// Picks a cost-balanced subset of ranks from the costliest and cheapest ends.
// ----------------------------------------------------------------------------
// Load and block-cost items are taken one per cycle while no run is in progress;
// rank costs drop into an insertion chain that keeps them sorted as they arrive.
// A start item first moves the sorted chain into a two-port memory, then runs
// the growth steps of the selection loop (limit check, memory read, multiply,
// compare), then writes each result item to the result queue, stalling while
// that queue is full. The next queued item is taken when the run has written
// its last result.
`timescale 1ns / 1ps
`default_nettype none
module lpt_rank_subset_selector_top
   import lrss_pkg::*;
#(
   parameter int MAX_RANKS = DEF_MAX_RANKS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [CMD_W-1:0]    req_cmd,
   input  wire logic [COST_W-1:0]   req_cost_value,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [IDX_W-1:0]         rsp_rank_index,
   output logic                     rsp_from_back,
   output logic                     rsp_none_selected,
   output logic                     rsp_last,
   input  wire logic                csr_write_en,
   input  wire logic                csr_index,
   input  wire logic [THRESH_W-1:0] csr_wdata
);
   logic [MAXSEL_W-1:0] max_selected_ff;
   logic [THRESH_W-1:0] balance_threshold_ff;

   lrss_item_type      q_item;
   logic               q_empty, q_pop;
   lrss_chain_ctl_type chain_ctl;
   lrss_entry_type     chain_head;
   logic               out_push, out_full;
   lrss_rsp_type       out_data, rsp_item;
   logic [$bits(lrss_rsp_type)-1:0] rsp_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_selected_ff      <= MAXSEL_RESET;
         balance_threshold_ff <= THRESH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_MAX_SELECTED: max_selected_ff      <= csr_wdata[MAXSEL_W-1:0];
            REG_THRESHOLD:    balance_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   lrss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .cmd        (req_cmd),
      .cost_value (req_cost_value),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .q_empty    (q_empty)
   );

   lrss_chain #(.MAX_RANKS(MAX_RANKS)) u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (chain_ctl),
      .head  (chain_head)
   );

   lrss_engine #(.MAX_RANKS(MAX_RANKS)) u_engine (
      .clock             (clock),
      .reset             (reset),
      .max_selected      (max_selected_ff),
      .balance_threshold (balance_threshold_ff),
      .q_item            (q_item),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .chain_ctl         (chain_ctl),
      .chain_head        (chain_head),
      .out_push          (out_push),
      .out_data          (out_data),
      .out_full          (out_full)
   );

   lrss_fifo #(
      .WIDTH($bits(lrss_rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_raw),
      .empty (rsp_empty)
   );

   assign rsp_item          = lrss_rsp_type'(rsp_raw);
   assign rsp_rank_index    = rsp_item.rank_index;
   assign rsp_from_back     = rsp_item.from_back;
   assign rsp_none_selected = rsp_item.none_selected;
   assign rsp_last          = rsp_item.last;
endmodule
`default_nettype wire
